/* design/presence_advert_parser_macros.svh */
// Assertion macros shared by the presence advertisement parser modules.
// No dependencies; take it in with `include before the module header.
`ifndef PRESENCE_ADVERT_PARSER_MACROS_SVH
`define PRESENCE_ADVERT_PARSER_MACROS_SVH

// Clocked property, off while reset is asserted (active-low reset).
`define PAB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that must hold in reset as well.
`define PAB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/pab_pkg.sv */
// Shared types and codes for the presence advertisement parser.
// No dependencies; every design module imports this package.
package pab_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_ONE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_TWO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_KIND  = 3'd4;

  // Status and error codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_TOO_MANY    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED   = 3'd4;

  // Result item kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Queue between parser front and output back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pab_in_t;

  typedef struct packed {
    logic              item_kind;
    logic [7:0]        report_index;
    logic [31:0]       report_id;
    logic signed [7:0] report_rssi;
    logic [31:0]       sender_id;
    logic [7:0]        version_seen;
    logic              is_anchor;
    logic [7:0]        report_total;
    logic [2:0]        status;
    logic              last_of_run;
  } pab_out_t;

  // One queue entry holds all results of one input byte: a report, a status, or both.
  typedef struct packed {
    logic        rep_v;
    logic        st_v;
    logic [7:0]  idx;
    logic [31:0] id;
    logic [7:0]  rssi;
    logic [31:0] sender;
    logic [7:0]  version;
    logic        anchor;
    logic [7:0]  total;
    logic [2:0]  status;
  } pab_entry_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic       valid;
    pab_entry_t entry;
  } pab_head_t;

endpackage

/* design/pab_front.sv */
// Parser front end: configuration registers, per-payload state, classification.
// Depends on pab_pkg; produces at most one queue entry per accepted byte.
module pab_front
  import pab_pkg::*;
#(
  parameter int unsigned MAX_REPORTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 accept_i,
  input  pab_in_t              data_i,
  output logic                 entry_push_o,
  output pab_entry_t           entry_o
);

  localparam logic [10:0] POS_MAX      = 11'd2047;
  localparam logic [10:0] MIN_LEN_ONE  = 11'd8;
  localparam logic [10:0] MIN_LEN_TWO  = 11'd9;
  localparam logic [2:0]  REPORT_BYTES = 3'd5;

  localparam logic [1:0] LAY_NONE = 2'd0;
  localparam logic [1:0] LAY_ONE  = 2'd1;
  localparam logic [1:0] LAY_TWO  = 2'd2;

  logic [7:0] magic_first_q, magic_second_q, ver_one_q, ver_two_q, anchor_kind_q;

  logic [10:0] pos_q, pos_c, pos_d;
  logic [2:0]  mod_q, mod_c, mod_d;
  logic [7:0]  ver_q, ver_c, ver_d;
  logic [31:0] sender_q, sender_c, sender_d;
  logic        anchor_q, anchor_c, anchor_d;
  logic [7:0]  count_q, count_c, count_d;
  logic [7:0]  done_q, done_c, done_d;
  logic [31:0] shift_q, shift_c, shift_d;
  logic [2:0]  err_q, err_c, err_d;
  logic        fin_q;

  logic [1:0] lay_c, lay_d;
  logic [2:0] ph;
  logic       in_reports;
  logic       rep_v;
  logic [1:0] lane;
  logic [2:0] status;
  logic [7:0] d;

  function automatic logic [1:0] layout_of(input logic [7:0] v, input logic [7:0] one,
                                           input logic [7:0] two);
    logic [1:0] r;
    if (v == one) r = LAY_ONE;
    else if (v == two) r = LAY_TWO;
    else r = LAY_NONE;
    return r;
  endfunction

  // Report phase from position mod 5: reports start at 8 (first layout) or 9.
  function automatic logic [2:0] phase_of(input logic [2:0] m, input logic second);
    logic [2:0] r;
    case (m)
      3'd0:    r = second ? 3'd1 : 3'd2;
      3'd1:    r = second ? 3'd2 : 3'd3;
      3'd2:    r = second ? 3'd3 : 3'd4;
      3'd3:    r = second ? 3'd4 : 3'd0;
      3'd4:    r = second ? 3'd0 : 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  assign d = data_i.data_byte;

  always_comb begin
    // A finished payload restarts from a clean state with this byte.
    pos_c    = fin_q ? '0 : pos_q;
    mod_c    = fin_q ? '0 : mod_q;
    ver_c    = fin_q ? '0 : ver_q;
    sender_c = fin_q ? '0 : sender_q;
    anchor_c = fin_q ? 1'b0 : anchor_q;
    count_c  = fin_q ? '0 : count_q;
    done_c   = fin_q ? '0 : done_q;
    shift_c  = fin_q ? '0 : shift_q;
    err_c    = fin_q ? ST_OK : err_q;

    lay_c = (pos_c >= 11'd3) ? layout_of(ver_c, ver_one_q, ver_two_q) : LAY_NONE;

    pos_d    = pos_c;
    mod_d    = mod_c;
    ver_d    = ver_c;
    sender_d = sender_c;
    anchor_d = anchor_c;
    count_d  = count_c;
    done_d   = done_c;
    shift_d  = shift_c;
    err_d    = err_c;
    rep_v    = 1'b0;
    lane     = 2'(pos_c - 11'd3);
    ph         = phase_of(mod_c, lay_c == LAY_TWO);
    in_reports = (lay_c == LAY_ONE) ? (pos_c >= MIN_LEN_ONE) : (pos_c >= MIN_LEN_TWO);

    if (pos_c == 11'd0) begin
      if (d != magic_first_q) err_d = ST_BAD_HEADER;
    end else if (pos_c == 11'd1) begin
      if (d != magic_second_q) err_d = ST_BAD_HEADER;
    end else if (pos_c == 11'd2) begin
      ver_d = d;
      if (layout_of(d, ver_one_q, ver_two_q) == LAY_NONE && err_c == ST_OK) begin
        err_d = ST_BAD_VERSION;
      end
    end else if (pos_c <= 11'd6) begin
      sender_d[{lane, 3'b000} +: 8] = d;
    end else if ((lay_c == LAY_ONE && pos_c == 11'd7) ||
                 (lay_c == LAY_TWO && pos_c == 11'd8)) begin
      count_d = d;
      if (d > 8'(MAX_REPORTS) && err_c == ST_OK) err_d = ST_TOO_MANY;
    end else if (lay_c == LAY_TWO && pos_c == 11'd7) begin
      anchor_d = (d == anchor_kind_q);
    end else if (lay_c != LAY_NONE && pos_c != POS_MAX) begin
      if (in_reports && err_c == ST_OK && done_c < count_c) begin
        if (ph != 3'd4) begin
          if (ph == 3'd0) shift_d = '0;
          // Merge into the lane: a layout change mid-payload can revisit one.
          shift_d[{ph[1:0], 3'b000} +: 8] = shift_d[{ph[1:0], 3'b000} +: 8] | d;
        end else begin
          rep_v  = 1'b1;
          done_d = done_c + 8'd1;
        end
      end
    end

    if (pos_c != POS_MAX) begin
      pos_d = pos_c + 11'd1;
      mod_d = (mod_c == REPORT_BYTES - 3'd1) ? 3'd0 : mod_c + 3'd1;
    end

    lay_d = layout_of(ver_d, ver_one_q, ver_two_q);
    if (err_d == ST_BAD_HEADER || pos_d < MIN_LEN_ONE) status = ST_BAD_HEADER;
    else if (err_d == ST_BAD_VERSION) status = ST_BAD_VERSION;
    else if (lay_d == LAY_TWO && pos_d < MIN_LEN_TWO) status = ST_BAD_HEADER;
    else if (err_d == ST_TOO_MANY) status = ST_TOO_MANY;
    else if (done_d < count_d) status = ST_TRUNCATED;
    else status = ST_OK;
  end

  assign entry_push_o   = accept_i && (rep_v || data_i.last_byte);
  assign entry_o.rep_v   = rep_v;
  assign entry_o.st_v    = data_i.last_byte;
  assign entry_o.idx     = done_c;
  assign entry_o.id      = shift_c;
  assign entry_o.rssi    = d;
  assign entry_o.sender  = sender_d;
  assign entry_o.version = ver_d;
  assign entry_o.anchor  = anchor_d;
  assign entry_o.total   = count_d;
  assign entry_o.status  = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_first_q  <= 8'd0;
      magic_second_q <= 8'd0;
      ver_one_q      <= 8'd1;
      ver_two_q      <= 8'd2;
      anchor_kind_q  <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC_FIRST:  magic_first_q  <= cfg_data_i;
        CFG_MAGIC_SECOND: magic_second_q <= cfg_data_i;
        CFG_VERSION_ONE:  ver_one_q      <= cfg_data_i;
        CFG_VERSION_TWO:  ver_two_q      <= cfg_data_i;
        CFG_ANCHOR_KIND:  anchor_kind_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      mod_q    <= '0;
      ver_q    <= '0;
      sender_q <= '0;
      anchor_q <= 1'b0;
      count_q  <= '0;
      done_q   <= '0;
      shift_q  <= '0;
      err_q    <= ST_OK;
      fin_q    <= 1'b0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      mod_q    <= mod_d;
      ver_q    <= ver_d;
      sender_q <= sender_d;
      anchor_q <= anchor_d;
      count_q  <= count_d;
      done_q   <= done_d;
      shift_q  <= shift_d;
      err_q    <= err_d;
      fin_q    <= data_i.last_byte;
    end
  end

endmodule

/* design/pab_queue.sv */
// Short entry queue between parser front and output back.
// Depends on pab_pkg and the assertion macro header.
`include "presence_advert_parser_macros.svh"
module pab_queue
  import pab_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pab_entry_t entry_i,
  output logic       full_o,
  input  logic       deq_i,
  output pab_head_t  head_o
);

  pab_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = deq_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `PAB_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH), "queue over depth")
  `PAB_ASSERT(a_ptr_match, clk_i, rst_ni, (wr_ptr_q - rd_ptr_q) == cnt_q[QPTR_W-1:0], "pointers out of step with count")
  `PAB_ASSERT(a_head_items, clk_i, rst_ni, head_o.valid |-> (head_o.entry.rep_v || head_o.entry.st_v), "queued entry holds no item")

endmodule

/* design/pab_back.sv */
// Output back end: turns each queue entry into one or two result items.
// Depends on pab_pkg and the assertion macro header.
`include "presence_advert_parser_macros.svh"
module pab_back
  import pab_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pab_head_t head_i,
  output logic      deq_o,
  input  logic      pop,
  output logic      empty,
  output pab_out_t  result_o
);

  logic phase_q, phase_d;
  logic show_rep, split, take;

  assign show_rep = head_i.entry.rep_v && !phase_q;
  assign split    = show_rep && head_i.entry.st_v;
  assign empty    = !head_i.valid;
  assign take     = pop && head_i.valid;
  // Hold the entry while its report goes out ahead of its status.
  assign deq_o    = take && !split;
  assign phase_d  = take ? split : phase_q;

  always_comb begin
    result_o.item_kind    = show_rep ? KIND_REPORT : KIND_STATUS;
    result_o.report_index = show_rep ? head_i.entry.idx
                                     : head_i.entry.idx + {7'd0, head_i.entry.rep_v};
    result_o.report_id    = show_rep ? head_i.entry.id : '0;
    result_o.report_rssi  = show_rep ? head_i.entry.rssi : '0;
    result_o.sender_id    = head_i.entry.sender;
    result_o.version_seen = head_i.entry.version;
    result_o.is_anchor    = head_i.entry.anchor;
    result_o.report_total = head_i.entry.total;
    result_o.status       = show_rep ? ST_OK : head_i.entry.status;
    result_o.last_of_run  = show_rep ? !head_i.entry.st_v : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= 1'b0;
    else         phase_q <= phase_d;
  end

  `PAB_ASSERT(a_phase_split, clk_i, rst_ni, phase_q |-> (head_i.valid && head_i.entry.rep_v && head_i.entry.st_v), "status phase without a split entry")
  `PAB_ASSERT(a_phase_hold, clk_i, rst_ni, (phase_q && !pop) |=> phase_q, "status phase dropped without pop")

endmodule

/* design/presence_advert_parser.sv */
// Presence advertisement parser: takes one payload byte per cycle while full is low, and
// yields report and status items; a byte's results are registered in the entry queue.
// The parser front classifies each byte; the back delivers one result per cycle while pop
// is high from a 4-entry queue, so a byte that completes a report and ends the payload
// gives a report then a status, and full rises only with four undelivered entries queued.
// Depends on pab_pkg, pab_front, pab_queue and pab_back.
module presence_advert_parser
  import pab_pkg::*;
#(
  parameter int unsigned MAX_REPORTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  pab_in_t              data_i,
  output logic                 empty,
  input  logic                 pop,
  output pab_out_t             result_o
);

  logic       accept;
  logic       entry_push;
  pab_entry_t entry;
  pab_head_t  head;
  logic       deq;

  assign accept = push && !full;

  pab_front #(
    .MAX_REPORTS(MAX_REPORTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_i      (data_i),
    .entry_push_o(entry_push),
    .entry_o     (entry)
  );

  pab_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (entry_push),
    .entry_i(entry),
    .full_o (full),
    .deq_i  (deq),
    .head_o (head)
  );

  pab_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .deq_o   (deq),
    .pop     (pop),
    .empty   (empty),
    .result_o(result_o)
  );

endmodule

/* tb/sv/presence_advert_parser_tb.sv */
// Self-checking testbench for presence_advert_parser: drives advertisement payloads
// through the parser and compares every report and status item with a predictor.
// Depends on pab_pkg and the presence_advert_parser RTL.
module presence_advert_parser_tb;
  import pab_pkg::*;

  localparam int unsigned MAX_REPORTS   = 16;
  localparam int unsigned POS_LIMIT     = 2047;
  localparam int unsigned REPORT_LEN    = 5;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_BYTES   = 190;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef enum int unsigned {LAYOUT_NONE, LAYOUT_ONE, LAYOUT_TWO} layout_e;

  // Tracks the parser state per byte and holds the results still owed by the block.
  class advert_tracker;
    logic [7:0]  magic_a, magic_b, ver_one, ver_two, anchor_code;
    int unsigned pos;
    logic [7:0]  version;
    logic [31:0] sender;
    logic        anchor;
    logic [7:0]  count;
    logic [7:0]  done;
    logic [31:0] peer_id;
    logic [2:0]  err;
    bit          ended;
    pab_out_t    due_results[$];
    int unsigned mismatches;

    function new();
      magic_a = 8'h00;
      magic_b = 8'h00;
      ver_one = 8'h01;
      ver_two = 8'h02;
      anchor_code = 8'h01;
      mismatches = 0;
      clear_payload();
    endfunction

    function void clear_payload();
      pos = 0;
      version = 8'h00;
      sender = 32'h0;
      anchor = 1'b0;
      count = 8'h00;
      done = 8'h00;
      peer_id = 32'h0;
      err = ST_OK;
      ended = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_MAGIC_FIRST:  magic_a = val;
        CFG_MAGIC_SECOND: magic_b = val;
        CFG_VERSION_ONE:  ver_one = val;
        CFG_VERSION_TWO:  ver_two = val;
        CFG_ANCHOR_KIND:  anchor_code = val;
        default: ;
      endcase
    endfunction

    // First layout wins when both codes match.
    function layout_e layout_code();
      if (version == ver_one) return LAYOUT_ONE;
      if (version == ver_two) return LAYOUT_TWO;
      return LAYOUT_NONE;
    endfunction

    function pab_out_t make_item(logic kind, logic [7:0] idx, logic [31:0] id,
                                 logic [7:0] rssi, logic [2:0] st);
      pab_out_t it;
      it.item_kind = kind;
      it.report_index = idx;
      it.report_id = id;
      it.report_rssi = rssi;
      it.sender_id = sender;
      it.version_seen = version;
      it.is_anchor = anchor;
      it.report_total = count;
      it.status = st;
      it.last_of_run = 1'b1;
      return it;
    endfunction

    function void take_byte(pab_in_t b);
      int unsigned p;
      int unsigned base;
      int unsigned phase;
      layout_e     lay;
      logic [7:0]  d;
      logic [2:0]  st;
      pab_out_t    it;
      if (ended) clear_payload();
      d = b.data_byte;
      p = pos;
      lay = (p >= 3) ? layout_code() : LAYOUT_NONE;
      if (p == 0) begin
        if (d != magic_a) err = ST_BAD_HEADER;
      end else if (p == 1) begin
        if (d != magic_b) err = ST_BAD_HEADER;
      end else if (p == 2) begin
        version = d;
        if (layout_code() == LAYOUT_NONE && err == ST_OK) err = ST_BAD_VERSION;
      end else if (p <= 6) begin
        sender = sender | (32'(d) << (8 * (p - 3)));
      end else if ((lay == LAYOUT_ONE && p == 7) || (lay == LAYOUT_TWO && p == 8)) begin
        count = d;
        if (d > MAX_REPORTS && err == ST_OK) err = ST_TOO_MANY;
      end else if (lay == LAYOUT_TWO && p == 7) begin
        anchor = (d == anchor_code);
      end else if (lay != LAYOUT_NONE && p < POS_LIMIT) begin
        base = (lay == LAYOUT_ONE) ? 8 : 9;
        // no reports once an error is recorded or the count is reached
        if (p >= base && err == ST_OK && done < count) begin
          phase = (p - base) % REPORT_LEN;
          if (phase < 4) begin
            if (phase == 0) peer_id = 32'h0;
            peer_id = peer_id | (32'(d) << (8 * phase));
          end else begin
            it = make_item(KIND_REPORT, done, peer_id, d, ST_OK);
            it.last_of_run = !b.last_byte;
            due_results.push_back(it);
            done = done + 8'd1;
          end
        end
      end
      if (pos < POS_LIMIT) pos++;
      if (b.last_byte) begin
        if (err == ST_BAD_HEADER || pos < 8) st = ST_BAD_HEADER;
        else if (err == ST_BAD_VERSION) st = ST_BAD_VERSION;
        else if (layout_code() == LAYOUT_TWO && pos < 9) st = ST_BAD_HEADER;
        else if (err == ST_TOO_MANY) st = ST_TOO_MANY;
        else if (done < count) st = ST_TRUNCATED;
        else st = ST_OK;
        due_results.push_back(make_item(KIND_STATUS, done, 32'h0, 8'h00, st));
        ended = 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void match_result(pab_out_t got);
      pab_out_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %h arrived with nothing expected", got);
        return;
      end
      want = due_results.pop_front();
      compare_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
      compare_field("report_index", 32'(want.report_index), 32'(got.report_index));
      compare_field("report_id", want.report_id, got.report_id);
      compare_field("report_rssi", 32'(want.report_rssi), 32'(got.report_rssi));
      compare_field("sender_id", want.sender_id, got.sender_id);
      compare_field("version_seen", 32'(want.version_seen), 32'(got.version_seen));
      compare_field("is_anchor", 32'(want.is_anchor), 32'(got.is_anchor));
      compare_field("report_total", 32'(want.report_total), 32'(got.report_total));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
  endclass

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = CFG_MAGIC_FIRST;
  logic [7:0]           cfg_data_i = 8'h00;
  logic                 push       = 1'b0;
  logic                 full;
  pab_in_t              data_i     = '0;
  logic                 empty;
  logic                 pop        = 1'b0;
  pab_out_t             result_o;

  advert_tracker tracker;
  bit            send_quiet  = 1'b0;
  bit            recv_quiet  = 1'b0;
  int unsigned   pop_hold    = 0;
  int unsigned   cycle_count = 0;

  // a good payload with report and status on one byte, then a lone bad byte,
  // and a second-layout payload of exactly eight bytes, too short for its header
  logic [7:0] opening_bytes [22] = '{
    8'h00, 8'h00, 8'h01, 8'h78, 8'h56, 8'h34, 8'h12, 8'h01,
    8'hEF, 8'hBE, 8'hAD, 8'hDE, 8'h80,
    8'hFF,
    8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01
  };

  presence_advert_parser #(.MAX_REPORTS(MAX_REPORTS)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .data_i     (data_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: take the head when pop was high, then choose the next stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) tracker.match_result(result_o);
      if (pop_hold > 0) begin
        pop_hold = pop_hold - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        pop_hold = recv_quiet ? 0 : pick_gap();
      end
    end
  end

  task automatic send_byte(input pab_in_t item);
    int unsigned gap;
    push <= 1'b1;
    data_i <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.take_byte(item);
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every owed result is out and the front has gone quiet.
  task automatic settle();
    push <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [7:0] m1, input logic [7:0] m2,
                              input logic [7:0] v1, input logic [7:0] v2,
                              input logic [7:0] ak);
    write_reg(CFG_MAGIC_FIRST, m1);
    write_reg(CFG_MAGIC_SECOND, m2);
    write_reg(CFG_VERSION_ONE, v1);
    write_reg(CFG_VERSION_TWO, v2);
    write_reg(CFG_ANCHOR_KIND, ak);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed payloads for the current registers, with bad magic, odd
  // versions, oversized counts, trailing bytes and cut-off payloads mixed in.
  task automatic build_payload(ref pab_in_t q[$], input int unsigned pad_to);
    logic [7:0]  bytes[$];
    logic [7:0]  ver;
    logic [7:0]  cnt;
    int unsigned r;
    int unsigned reps;
    int unsigned cut;
    pab_in_t     item;
    r = $urandom_range(0, 99);
    ver = (r < 45) ? tracker.ver_one : ((r < 90) ? tracker.ver_two : rand_byte());
    bytes.push_back(tracker.magic_a);
    bytes.push_back(tracker.magic_b);
    if ($urandom_range(0, 19) == 0)
      bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    bytes.push_back(ver);
    repeat (4) bytes.push_back(rand_byte());
    if (ver == tracker.ver_two && ver != tracker.ver_one)
      bytes.push_back($urandom_range(0, 1) ? tracker.anchor_code : rand_byte());
    r = $urandom_range(0, 99);
    if (r < 70) cnt = 8'($urandom_range(0, 4));
    else if (r < 85) cnt = 8'($urandom_range(5, MAX_REPORTS));
    else if (r < 90) cnt = 8'(MAX_REPORTS);
    else cnt = 8'($urandom_range(MAX_REPORTS + 1, 255));
    bytes.push_back(cnt);
    reps = (cnt > MAX_REPORTS) ? $urandom_range(0, 2) : int'(cnt);
    repeat (reps * REPORT_LEN) bytes.push_back(rand_byte());
    r = $urandom_range(0, 99);
    if (r < 15) begin
      repeat ($urandom_range(1, 4)) bytes.push_back(rand_byte());
    end else if (r < 30) begin
      cut = $urandom_range(1, bytes.size());
      while (bytes.size() > cut) void'(bytes.pop_back());
    end
    while (bytes.size() < pad_to) bytes.push_back(rand_byte());
    q.delete();
    foreach (bytes[i]) begin
      item.data_byte = bytes[i];
      item.last_byte = (i == bytes.size() - 1);
      q.push_back(item);
    end
  endtask

  initial begin
    pab_in_t     batch[$];
    pab_in_t     carry[$];
    pab_in_t     item;
    int unsigned sent;
    int unsigned split;
    int unsigned k;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values
    foreach (opening_bytes[i]) begin
      item.data_byte = opening_bytes[i];
      item.last_byte = (i == 12 || i == 13 || i == 21);
      send_byte(item);
    end

    for (int unsigned ph = 1; ph <= PHASES; ph++) begin
      settle();
      case (ph)
        1: program_regs(8'hA5, 8'h5A, 8'h01, 8'h02, 8'h01);
        2: program_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF);
        3: program_regs(8'hFF, 8'h00, 8'h07, 8'h07, 8'h00);
        6: program_regs(rand_byte(), rand_byte(), 8'h00, 8'hFF, rand_byte());
        default: program_regs(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
      endcase
      send_quiet = (ph == 2);
      recv_quiet = (ph == 4);
      // finish the payload left open before the register change
      foreach (carry[i]) send_byte(carry[i]);
      carry.delete();
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_payload(batch, 0);
        if (sent + batch.size() >= PHASE_BYTES && ph % 2 == 1 && batch.size() > 1) begin
          split = $urandom_range(1, batch.size() - 1);
          for (k = 0; k < split; k++) send_byte(batch[k]);
          for (k = split; k < batch.size(); k++) carry.push_back(batch[k]);
        end else begin
          foreach (batch[i]) send_byte(batch[i]);
        end
        sent += batch.size();
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/pab_pkg.sv
design/pab_front.sv
design/pab_queue.sv
design/pab_back.sv
design/presence_advert_parser.sv
tb/sv/presence_advert_parser_tb.sv
